// ===== sv/tmeta_pkg.sv =====
// Shared types and constants for the throughput meter with remaining-time estimate.
package tmeta_pkg;

    localparam int WINDOW_BINS_DEF = 50;
    localparam int INTERVAL_RST    = 100;

    localparam int OP_W     = 2;
    localparam int BIN_W    = 32;
    localparam int BYTES_W  = 48;
    localparam int SPEED_W  = 42;
    localparam int DAYS_W   = 32;
    localparam int HOURS_W  = 5;
    localparam int MINS_W   = 6;
    localparam int SECS_W   = 6;
    localparam int IVL_W    = 16;

    localparam int DIV_W    = 48;
    localparam int DCNT_W   = 6;
    localparam int REM_DAY_W = 17;
    localparam int REM_HR_W  = 12;

    localparam int MS_PER_S   = 1000;
    localparam int S_PER_DAY  = 86400;
    localparam int S_PER_HOUR = 3600;
    localparam int S_PER_MIN  = 60;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BIN_W-1:0]   amount;
        logic [BYTES_W-1:0] received_bytes;
        logic [BYTES_W-1:0] total_bytes;
    } in_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               eta_known;
        logic [BYTES_W-1:0] eta_seconds;
        logic [DAYS_W-1:0]  eta_days;
        logic [HOURS_W-1:0] eta_hours;
        logic [MINS_W-1:0]  eta_minutes;
        logic [SECS_W-1:0]  eta_secs_shown;
    } out_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [DCNT_W-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== sv/tmeta_ring.sv =====
// Bin ring storage: one write port, one registered read port.
module tmeta_ring #(
    parameter int DEPTH  = tmeta_pkg::WINDOW_BINS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [tmeta_pkg::BIN_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [tmeta_pkg::BIN_W-1:0] rd_data
);

    logic [tmeta_pkg::BIN_W-1:0] mem [DEPTH];
    logic [tmeta_pkg::BIN_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tmeta_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
module tmeta_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  tmeta_pkg::div_req_t req,
    output tmeta_pkg::div_rsp_t rsp
);

    localparam int W = tmeta_pkg::DIV_W;

    logic [W-1:0]                  q_reg, q_next;
    logic [W-1:0]                  r_reg, r_next;
    logic [W-1:0]                  d_reg, d_next;
    logic [tmeta_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [W:0]                    trial;
    logic [W:0]                    diff;
    logic                          ge;

    always_comb begin
        trial     = {r_reg, q_reg[W-1]};
        diff      = trial - {1'b0, d_reg};
        ge        = (trial >= {1'b0, d_reg});
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            q_next    = req.dividend << (tmeta_pkg::DCNT_W'(W) - req.nbits);
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            r_next   = ge ? diff[W-1:0] : trial[W-1:0];
            q_next   = {q_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tmeta_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

endmodule

// ===== sv/throughput_meter_with_eta.sv =====
// Top level: windowed throughput meter with remaining-time estimate.
//
// Add and set requests are applied in the idle state. A tick request pushes the current bin
// into a ring held in one synchronous memory, then runs up to four divisions on one shared
// bit-serial divider, one quotient bit per cycle: window average, bytes per second and,
// only when the remaining time is known, whole days as the remaining bytes over speed
// times 86400 and the seconds of the last day as the leftover bytes over speed. Hours and
// minutes follow from reciprocal multiplications and seconds from a subtraction, one step
// per cycle. No new request is taken during a tick; a finished result waits in the output
// register without blocking further requests, but holds the next tick in its output state
// until it is taken. Ring entries not yet written are masked by the fill count, so there
// is no clearing pass after reset.
module throughput_meter_with_eta #(
    parameter int WINDOW_BINS = tmeta_pkg::WINDOW_BINS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tmeta_pkg::in_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tmeta_pkg::out_t                 m_data,
    input  logic                            cfg_wr_en,
    input  logic [tmeta_pkg::IVL_W-1:0]     cfg_wr_data
);

    localparam int POS_W  = (WINDOW_BINS > 1) ? $clog2(WINDOW_BINS) : 1;
    localparam int CNT_W  = $clog2(WINDOW_BINS + 1);
    localparam int SUM_W  = tmeta_pkg::BIN_W + CNT_W;
    localparam int BIN_W  = tmeta_pkg::BIN_W;
    localparam int BYT_W  = tmeta_pkg::BYTES_W;
    localparam int SPD_W  = tmeta_pkg::SPEED_W;
    localparam int DIV_W  = tmeta_pkg::DIV_W;
    localparam int DCNT_W = tmeta_pkg::DCNT_W;
    localparam int RD_W   = tmeta_pkg::REM_DAY_W;
    localparam int RH_W   = tmeta_pkg::REM_HR_W;
    localparam int DAYD_W = SPD_W + RD_W;

    // x / 3600 = ((x >> 4) * 9321) >> 21 for x < 86400
    localparam int HR_RCP = 9321;
    localparam int HR_SH  = 21;
    localparam int HRP_W  = 27;
    // x / 60 = ((x >> 2) * 1093) >> 14 for x < 3600
    localparam int MN_RCP = 1093;
    localparam int MN_SH  = 14;
    localparam int MNP_W  = 21;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_AVG  = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_SPD  = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_ETA  = 4'd6;
    localparam logic [3:0] ST_DAY  = 4'd7;
    localparam logic [3:0] ST_HR   = 4'd8;
    localparam logic [3:0] ST_MIN  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;
    localparam logic [3:0] ST_SEC  = 4'd11;
    localparam logic [3:0] ST_SCS  = 4'd12;

    logic [3:0]                      state_reg, state_next;
    logic                            pend_reg, pend_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic [BIN_W-1:0]                cur_bin_reg, cur_bin_next;
    logic [SUM_W-1:0]                sum_reg, sum_next;
    logic [BYT_W-1:0]                got_reg, got_next;
    logic [BYT_W-1:0]                want_reg, want_next;
    logic [tmeta_pkg::IVL_W-1:0]     ivl_reg, ivl_next;
    logic [BIN_W-1:0]                avg_reg, avg_next;
    logic [SPD_W-1:0]                prod_reg, prod_next;
    logic [SPD_W-1:0]                speed_reg, speed_next;
    logic                            known_reg, known_next;
    logic [BYT_W-1:0]                t_reg, t_next;
    logic [tmeta_pkg::DAYS_W-1:0]    days_reg, days_next;
    logic [tmeta_pkg::HOURS_W-1:0]   hours_reg, hours_next;
    logic [tmeta_pkg::MINS_W-1:0]    mins_reg, mins_next;
    logic [tmeta_pkg::SECS_W-1:0]    secs_reg, secs_next;
    logic [RD_W-1:0]                 rem_reg, rem_next;
    logic                            m_valid_reg, m_valid_next;
    tmeta_pkg::out_t                 m_data_reg, m_data_next;

    tmeta_pkg::div_req_t             div_req;
    tmeta_pkg::div_rsp_t             div_rsp;

    logic                            accept;
    logic                            full;
    logic                            ring_rd_en;
    logic                            ring_wr_en;
    logic [BIN_W-1:0]                ring_rd_data;
    logic [BIN_W-1:0]                old_bin;
    logic [BIN_W:0]                  add_sum;
    logic [BYT_W-1:0]                remaining;
    logic [tmeta_pkg::IVL_W-1:0]     ivl_eff;
    logic                            div_state;
    logic [tmeta_pkg::SECS_W-1:0]    secs_shown;
    logic [DAYD_W-1:0]               day_div;
    logic                            day_ovf;
    logic [HRP_W-1:0]                hr_prod;
    logic [MNP_W-1:0]                min_prod;
    logic [RH_W-1:0]                 sec_diff;

    tmeta_ring #(
        .DEPTH  (WINDOW_BINS),
        .ADDR_W (POS_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (pos_reg),
        .wr_data (cur_bin_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data)
    );

    tmeta_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign full       = (fill_reg == CNT_W'(WINDOW_BINS));
    assign ring_rd_en = accept && (s_data.op == tmeta_pkg::OP_TICK);
    assign ring_wr_en = (state_reg == ST_RD);
    assign old_bin    = full ? ring_rd_data : '0;
    assign add_sum    = {1'b0, cur_bin_reg} + {1'b0, s_data.amount};
    assign remaining  = (want_reg > got_reg) ? (want_reg - got_reg) : '0;
    assign ivl_eff    = (ivl_reg == '0) ? tmeta_pkg::IVL_W'(1) : ivl_reg;
    assign div_state  = (state_reg == ST_AVG) || (state_reg == ST_SPD) ||
                        (state_reg == ST_ETA) || (state_reg == ST_DAY);
    assign secs_shown = (mins_reg != '0) ? '0 :
                        ((secs_reg == '0) ? tmeta_pkg::SECS_W'(1) : secs_reg);
    assign day_div    = DAYD_W'(speed_reg) * DAYD_W'(tmeta_pkg::S_PER_DAY);
    assign day_ovf    = |day_div[DAYD_W-1:BYT_W];
    assign hr_prod    = HRP_W'(rem_reg[RD_W-1:4]) * HRP_W'(HR_RCP);
    assign min_prod   = MNP_W'(rem_reg[RH_W-1:2]) * MNP_W'(MN_RCP);
    assign sec_diff   = rem_reg[RH_W-1:0] - RH_W'(mins_reg) * RH_W'(tmeta_pkg::S_PER_MIN);

    always_comb begin
        div_req.start    = div_state && !pend_reg;
        div_req.dividend = '0;
        div_req.divisor  = DIV_W'(1);
        div_req.nbits    = DCNT_W'(DIV_W);
        unique case (state_reg)
            ST_AVG: begin
                div_req.dividend = DIV_W'(sum_reg);
                div_req.divisor  = DIV_W'(fill_reg);
                div_req.nbits    = DCNT_W'(SUM_W);
            end
            ST_SPD: begin
                div_req.dividend = DIV_W'(prod_reg);
                div_req.divisor  = DIV_W'(ivl_eff);
                div_req.nbits    = DCNT_W'(SPD_W);
            end
            ST_ETA: begin
                div_req.dividend = remaining;
                div_req.divisor  = day_ovf ? '1 : day_div[DIV_W-1:0];
            end
            ST_DAY: begin
                div_req.dividend = t_reg;
                div_req.divisor  = DIV_W'(speed_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        cur_bin_next = cur_bin_reg;
        sum_next     = sum_reg;
        got_next     = got_reg;
        want_next    = want_reg;
        ivl_next     = cfg_wr_en ? cfg_wr_data : ivl_reg;
        avg_next     = avg_reg;
        prod_next    = prod_reg;
        speed_next   = speed_reg;
        known_next   = known_reg;
        t_next       = t_reg;
        days_next    = days_reg;
        hours_next   = hours_reg;
        mins_next    = mins_reg;
        secs_next    = secs_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (div_req.start) begin
            pend_next = 1'b1;
        end else if (div_rsp.done) begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.op)
                        tmeta_pkg::OP_ADD: begin
                            cur_bin_next = add_sum[BIN_W] ? '1 : add_sum[BIN_W-1:0];
                        end
                        tmeta_pkg::OP_SET: begin
                            got_next  = s_data.received_bytes;
                            want_next = s_data.total_bytes;
                        end
                        tmeta_pkg::OP_TICK: begin
                            state_next = ST_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                sum_next     = sum_reg - SUM_W'(old_bin) + SUM_W'(cur_bin_reg);
                cur_bin_next = '0;
                pos_next     = (pos_reg == POS_W'(WINDOW_BINS - 1)) ? '0 : pos_reg + 1'b1;
                if (!full) begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_AVG;
            end
            ST_AVG: begin
                if (pend_reg && div_rsp.done) begin
                    avg_next   = div_rsp.quot[BIN_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = SPD_W'(avg_reg) * SPD_W'(tmeta_pkg::MS_PER_S);
                state_next = ST_SPD;
            end
            ST_SPD: begin
                if (pend_reg && div_rsp.done) begin
                    speed_next = div_rsp.quot[SPD_W-1:0];
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                known_next = (want_reg != '0) && (speed_reg != '0);
                state_next = ((want_reg != '0) && (speed_reg != '0)) ? ST_ETA : ST_OUT;
            end
            ST_ETA: begin
                if (pend_reg && div_rsp.done) begin
                    days_next  = day_ovf ? '0 : div_rsp.quot[tmeta_pkg::DAYS_W-1:0];
                    t_next     = day_ovf ? remaining : div_rsp.rem;
                    state_next = ST_DAY;
                end
            end
            ST_DAY: begin
                if (pend_reg && div_rsp.done) begin
                    rem_next   = div_rsp.quot[RD_W-1:0];
                    state_next = ST_HR;
                end
            end
            ST_HR: begin
                hours_next = hr_prod[HR_SH +: tmeta_pkg::HOURS_W];
                t_next     = BYT_W'(days_reg) * BYT_W'(tmeta_pkg::S_PER_DAY) + BYT_W'(rem_reg);
                state_next = ST_MIN;
            end
            ST_MIN: begin
                rem_next   = rem_reg - RD_W'(hours_reg) * RD_W'(tmeta_pkg::S_PER_HOUR);
                state_next = ST_SEC;
            end
            ST_SEC: begin
                mins_next  = min_prod[MN_SH +: tmeta_pkg::MINS_W];
                state_next = ST_SCS;
            end
            ST_SCS: begin
                secs_next  = sec_diff[tmeta_pkg::SECS_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.speed          = speed_reg;
                    m_data_next.eta_known      = known_reg;
                    m_data_next.eta_seconds    = known_reg ? t_reg : '0;
                    m_data_next.eta_days       = known_reg ? days_reg : '0;
                    m_data_next.eta_hours      = known_reg ? hours_reg : '0;
                    m_data_next.eta_minutes    = known_reg ? mins_reg : '0;
                    m_data_next.eta_secs_shown = known_reg ? secs_shown : '0;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        avg_reg    <= avg_next;
        prod_reg   <= prod_next;
        speed_reg  <= speed_next;
        known_reg  <= known_next;
        t_reg      <= t_next;
        days_reg   <= days_next;
        hours_reg  <= hours_next;
        mins_reg   <= mins_next;
        secs_reg   <= secs_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            cur_bin_reg <= '0;
            sum_reg     <= '0;
            got_reg     <= '0;
            want_reg    <= '0;
            ivl_reg     <= tmeta_pkg::IVL_W'(tmeta_pkg::INTERVAL_RST);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            cur_bin_reg <= cur_bin_next;
            sum_reg     <= sum_next;
            got_reg     <= got_next;
            want_reg    <= want_next;
            ivl_reg     <= ivl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(WINDOW_BINS) && pos_reg < POS_W'(WINDOW_BINS))
        else $error("fill count or ring position out of range");

    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    a_unknown_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.eta_known |-> m_data.eta_seconds == '0 && m_data.eta_days == '0)
        else $error("unknown remaining time carries nonzero fields");

    a_ring_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_wr_en |-> $past(ring_rd_en))
        else $error("ring written without the preceding read");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the windowed throughput meter: random requests, ETA prediction.
module testbench;
    import tmeta_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 2500;
    localparam int HOLD_AT      = 40;
    localparam int PHASE_ITEMS  = 242;
    localparam logic [63:0] MIN_PER_DAY = 64'(S_PER_DAY / S_PER_MIN);

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_t                s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               cfg_wr_en = 1'b0;
    logic [IVL_W-1:0]   cfg_wr_data = '0;

    throughput_meter_with_eta DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // meter state as the bench sees it
    logic [BIN_W-1:0]   bin_hist [WINDOW_BINS_DEF];
    int                 hist_pos;
    int                 hist_fill;
    logic [BIN_W-1:0]   open_bin;
    logic [63:0]        hist_sum;
    logic [BYTES_W-1:0] seen_bytes;
    logic [BYTES_W-1:0] goal_bytes;
    logic [IVL_W-1:0]   meter_interval;

    in_t  feed_queue[$];
    out_t eta_expected[$];
    int   requests_queued = 0;
    int   requests_taken  = 0;
    int   results_seen    = 0;
    int   mismatch_count  = 0;
    int   quiet_cycles    = 0;
    logic req_taken       = 1'b0;
    logic no_idle         = 1'b0;
    int   hold_left       = 0;
    logic hold_done       = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic meter_step(input in_t req);
        logic [BIN_W:0] bin_sum;
        logic [63:0]    avg, spd, ivl, remain, secs_total, days, hours, mins, secs;
        out_t           res;
        case (req.op)
            OP_ADD: begin
                bin_sum  = {1'b0, open_bin} + {1'b0, req.amount};
                open_bin = bin_sum[BIN_W] ? '1 : bin_sum[BIN_W-1:0];
            end
            OP_SET: begin
                seen_bytes = req.received_bytes;
                goal_bytes = req.total_bytes;
            end
            OP_TICK: begin
                hist_sum = hist_sum - bin_hist[hist_pos] + open_bin;
                bin_hist[hist_pos] = open_bin;
                open_bin = '0;
                hist_pos = (hist_pos + 1 >= WINDOW_BINS_DEF) ? 0 : hist_pos + 1;
                if (hist_fill < WINDOW_BINS_DEF)
                    hist_fill++;
                avg = hist_sum / hist_fill;
                ivl = (meter_interval == 0) ? 64'd1 : 64'(meter_interval);
                spd = (avg * MS_PER_S) / ivl;
                spd = spd & ((64'd1 << SPEED_W) - 1);
                res = '0;
                res.speed = spd[SPEED_W-1:0];
                if (goal_bytes != 0 && spd != 0) begin
                    remain     = (goal_bytes > seen_bytes) ? 64'(goal_bytes - seen_bytes) : 64'd0;
                    secs_total = remain / spd;
                    days  = secs_total / S_PER_DAY;
                    hours = secs_total / S_PER_HOUR - days * 24;
                    mins  = secs_total / S_PER_MIN - days * MIN_PER_DAY - hours * 60;
                    secs  = secs_total % S_PER_MIN;
                    res.eta_known      = 1'b1;
                    res.eta_seconds    = secs_total[BYTES_W-1:0];
                    res.eta_days       = days[DAYS_W-1:0];
                    res.eta_hours      = hours[HOURS_W-1:0];
                    res.eta_minutes    = mins[MINS_W-1:0];
                    res.eta_secs_shown = (mins == 0) ? ((secs == 0) ? 6'd1 : secs[SECS_W-1:0])
                                                     : 6'd0;
                end
                eta_expected.push_back(res);
            end
            default: ;
        endcase
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (feed_queue.size() > 0 && (no_idle || $urandom_range(99) >= 24)) begin
                s_data  <= feed_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge aclk) begin
        if (!hold_done && results_seen == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 24);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            req_taken    <= 1'b0;
            quiet_cycles = 0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                requests_taken++;
                meter_step(s_data);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (eta_expected.size() == 0) begin
                    flag_mismatch("result with no request pending");
                end else begin
                    want = eta_expected.pop_front();
                    check_field("speed", 64'(m_data.speed), 64'(want.speed));
                    check_field("eta_known", 64'(m_data.eta_known), 64'(want.eta_known));
                    check_field("eta_seconds", 64'(m_data.eta_seconds), 64'(want.eta_seconds));
                    check_field("eta_days", 64'(m_data.eta_days), 64'(want.eta_days));
                    check_field("eta_hours", 64'(m_data.eta_hours), 64'(want.eta_hours));
                    check_field("eta_minutes", 64'(m_data.eta_minutes), 64'(want.eta_minutes));
                    check_field("eta_secs_shown", 64'(m_data.eta_secs_shown),
                                64'(want.eta_secs_shown));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [BYTES_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[BYTES_W-1:0];
    endfunction

    task automatic offer(input logic [OP_W-1:0] op, input logic [BIN_W-1:0] amt,
                         input logic [BYTES_W-1:0] rcv, input logic [BYTES_W-1:0] tot);
        in_t r;
        r.op             = op;
        r.amount         = amt;
        r.received_bytes = rcv;
        r.total_bytes    = tot;
        feed_queue.push_back(r);
        requests_queued++;
    endtask

    task automatic write_interval(input logic [IVL_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        meter_interval = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (!(requests_taken == requests_queued && eta_expected.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int n);
        int                 counted;
        int                 r;
        logic [BIN_W-1:0]   amt;
        logic [BYTES_W-1:0] rcv, tot;
        counted = 0;
        while (counted < n) begin
            r   = $urandom_range(99);
            amt = $urandom();
            rcv = rand48();
            tot = rand48();
            if (r < 5) begin
                offer(OP_UNUSED, amt, rcv, tot);
            end else if (r < 50) begin
                case ($urandom_range(3))
                    0: amt = $urandom_range(5000);
                    1: amt = $urandom_range(1 << 20);
                    2: amt = 32'hFFFF_FFFF - $urandom_range(100);
                    default: ;
                endcase
                offer(OP_ADD, amt, rcv, tot);
                counted++;
            end else if (r < 65) begin
                case ($urandom_range(9))
                    0: tot = '0;
                    1: tot = rcv;
                    2: ;
                    3, 4, 5: begin
                        rcv = 48'($urandom());
                        tot = rcv + 48'($urandom_range(2000000));
                    end
                    6, 7: rcv = tot >> $urandom_range(1, 8);
                    default: begin
                        rcv = 48'($urandom_range(1000));
                        tot = rcv + 48'($urandom_range(100000));
                    end
                endcase
                offer(OP_SET, amt, rcv, tot);
                counted++;
            end else begin
                offer(OP_TICK, amt, rcv, tot);
                counted++;
            end
        end
    endtask

    initial begin : stimulus
        logic [IVL_W-1:0] settings [6];
        int i;
        foreach (bin_hist[k])
            bin_hist[k] = '0;
        hist_pos       = 0;
        hist_fill      = 0;
        open_bin       = '0;
        hist_sum       = '0;
        seen_bytes     = '0;
        goal_bytes     = '0;
        meter_interval = IVL_W'(INTERVAL_RST);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty window, saturation, overshoot, unknown total, ignored op
        offer(OP_TICK, '0, '0, '0);
        offer(OP_UNUSED, '1, '1, '1);
        offer(OP_SET, '0, '0, '1);
        offer(OP_ADD, '0, '0, '0);
        offer(OP_ADD, '1, '0, '0);
        offer(OP_ADD, '1, '1, '1);
        offer(OP_TICK, '1, '1, '1);
        offer(OP_SET, '0, '1, 48'd1);
        offer(OP_ADD, 32'd1000, '0, '0);
        offer(OP_TICK, '0, '0, '0);
        offer(OP_SET, '0, '0, '0);
        offer(OP_ADD, 32'd5, '0, '0);
        offer(OP_TICK, '0, '0, '0);
        offer(OP_SET, '0, 48'd0, 48'd1_000_000);
        offer(OP_ADD, 32'd123456, '0, '0);
        offer(OP_TICK, '0, '0, '0);
        offer(OP_SET, '0, 48'd500, 48'd90_000_000);
        offer(OP_TICK, '0, '0, '0);
        offer(OP_SET, '0, '1, '1);
        offer(OP_TICK, '0, '0, '0);
        wait_drained();

        settings[0] = IVL_W'(INTERVAL_RST);
        settings[1] = 16'd1;
        settings[2] = 16'hFFFF;
        settings[3] = 16'd0;
        settings[4] = IVL_W'($urandom_range(2, 16'hFFFE));
        settings[5] = 16'd1000;
        for (i = 0; i < 6; i++) begin
            write_interval(settings[i]);
            no_idle = (i == 2);
            queue_random(PHASE_ITEMS);
            wait_drained();
        end
        no_idle = 1'b0;

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
